// File: rtl/smnpp_pkg.sv
// Shared widths, register indexes and the result group type of the nibble plane packer.
package smnpp_pkg;

  localparam int AddrW   = 23;
  localparam int SampleW = 16;
  localparam int ByteW   = 8;
  localparam int CfgIdxW = 2;
  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  localparam logic [CfgIdxW-1:0] RegDirection  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPixelCount = 2'd1;

  // Number of results in a group.
  localparam logic [1:0] GroupOne   = 2'd1;
  localparam logic [1:0] GroupThree = 2'd3;

  typedef struct packed {
    logic [1:0]                   count;
    logic [2:0][AddrW-1:0]        addr;
    logic [2:0][ByteW-1:0]        data;
    logic signed [SampleW-1:0]    sample;
  } smnpp_group_t;

endpackage

// File: rtl/smnpp_core.sv
// Configuration registers, pixel position state and the per-pixel encode and decode logic.
module smnpp_core import smnpp_pkg::*; #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [AddrW-1:0]          cfg_data,
  input  logic                      load,
  input  logic signed [SampleW-1:0] sample,
  input  logic [ByteW-1:0]          low_byte,
  input  logic [ByteW-1:0]          plane_b_byte,
  input  logic [ByteW-1:0]          plane_c_byte,
  output smnpp_group_t              group
);

  localparam logic [AddrW:0] MaxPix = (AddrW+1)'(MAX_PIXELS);

  logic             direction;
  logic [AddrW-1:0] pixel_count;
  logic [AddrW-1:0] pixel_index;
  logic [AddrW-1:0] pixel_index_next;
  logic [3:0]       pending_b;
  logic [3:0]       pending_c;

  logic [AddrW-1:0]   npix;
  logic [AddrW-1:0]   p;
  logic               odd;
  logic               last_pix;
  logic [AddrW:0]     half;
  logic [AddrW:0]     addr_b;
  logic [AddrW:0]     addr_c;
  logic [SampleW-1:0] mag;
  logic [SampleW-1:0] u_enc;
  logic [3:0]         nb;
  logic [3:0]         nc;
  logic [ByteW-1:0]   byte_b;
  logic [ByteW-1:0]   byte_c;
  logic [ByteW-1:0]   hi_dec;
  logic [SampleW-1:0] u_dec;
  logic [SampleW-2:0] s_dec;
  logic [SampleW-1:0] v_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      pixel_count <= AddrW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        RegDirection:  direction   <= cfg_data[0];
        RegPixelCount: pixel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pixel_count == '0) begin
      npix = AddrW'(1);
    end else if ({1'b0, pixel_count} > MaxPix) begin
      npix = MaxPix[AddrW-1:0];
    end else begin
      npix = pixel_count;
    end
    p        = (pixel_index < npix) ? pixel_index : '0;
    odd      = p[0];
    last_pix = (p == npix - AddrW'(1));
    half     = ({1'b0, npix} + (AddrW+1)'(1)) >> 1;
    addr_b   = {1'b0, npix} + {2'b00, p[AddrW-1:1]};
    addr_c   = addr_b + half;
    pixel_index_next = (p + AddrW'(1) >= npix) ? '0 : p + AddrW'(1);

    // Sign-magnitude code with the sign in bit 0; the most negative sample wraps to 1.
    mag = -sample;
    if (sample[SampleW-1]) begin
      u_enc = {mag[SampleW-2:0], 1'b1};
    end else begin
      u_enc = {sample[SampleW-2:0], 1'b0};
    end
    nb = u_enc[11:8];
    nc = u_enc[15:12];
    byte_b = {odd ? pending_b : nb, odd ? nb : 4'h0};
    byte_c = {odd ? pending_c : nc, odd ? nc : 4'h0};

    if (odd) begin
      hi_dec = {plane_c_byte[3:0], plane_b_byte[3:0]};
    end else begin
      hi_dec = {plane_c_byte[7:4], plane_b_byte[7:4]};
    end
    u_dec = {hi_dec, low_byte};
    s_dec = u_dec[SampleW-1:1];
    if (u_dec[0]) begin
      v_dec = (s_dec == '0) ? 16'h8000 : -{1'b0, s_dec};
    end else begin
      v_dec = {1'b0, s_dec};
    end

    group.addr[0] = direction ? '0 : p;
    group.data[0] = direction ? '0 : u_enc[ByteW-1:0];
    group.addr[1] = addr_b[AddrW-1:0];
    group.data[1] = byte_b;
    group.addr[2] = addr_c[AddrW-1:0];
    group.data[2] = byte_c;
    group.sample  = direction ? v_dec : '0;
    group.count   = (!direction && (odd || last_pix)) ? GroupThree : GroupOne;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      pending_b   <= '0;
      pending_c   <= '0;
    end else if (load) begin
      pixel_index <= pixel_index_next;
      if (!direction && !odd) begin
        pending_b <= nb;
        pending_c <= nc;
      end
    end
  end

endmodule

// File: rtl/smnpp_outbuf.sv
// Result register that holds one group of results and hands them out one transfer at a time.
module smnpp_outbuf import smnpp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  smnpp_group_t        group,
  input  logic                load,
  output logic                can_load,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast
);

  smnpp_group_t held;
  logic         valid;
  logic [1:0]   pos;
  logic         take;
  logic         at_last;

  assign at_last  = (pos == held.count - 2'd1);
  assign take     = valid && m_tready;
  assign can_load = !valid || (m_tready && at_last);

  assign m_tvalid = valid;
  assign m_tlast  = at_last;
  assign m_tdata  = {1'b0, held.sample, held.data[pos], held.addr[pos]};

  always_ff @(posedge clk) begin
    if (load) begin
      held <= group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      pos   <= '0;
    end else if (take) begin
      if (at_last) begin
        valid <= 1'b0;
        pos   <= '0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

endmodule

// File: rtl/sign_magnitude_nibble_plane_packer_top.sv
// Top level of the sign-magnitude nibble plane packer.
// An input transfer is taken in any cycle in which the result register is empty or
// is handing out its final result, so decode items and encode items for an even,
// non-final pixel go through at one per clock while m_tready is high. An encode item
// for an odd pixel, or for the final pixel of the region, yields three results
// (plane A, then plane B, then plane C byte), and because the single output port moves
// one result per transfer such an item occupies the output for three transfers. Plane
// offsets follow pixel_count. Both direction and pixel_count come in on the always-ready
// cfg channel, only while no item is in flight: a user rule the block does not enforce.
module sign_magnitude_nibble_plane_packer_top import smnpp_pkg::*; #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [AddrW-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  // sample[15:0], low_byte[23:16], plane_b_byte[31:24], plane_c_byte[39:32]
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // out_addr[22:0], out_byte[30:23], out_sample[46:31], zero pad[47]
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast
);

  smnpp_group_t group;
  logic         load;

  assign cfg_ready = 1'b1;
  assign load      = s_tvalid && s_tready;

  smnpp_core #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .load        (load),
    .sample      (s_tdata[15:0]),
    .low_byte    (s_tdata[23:16]),
    .plane_b_byte(s_tdata[31:24]),
    .plane_c_byte(s_tdata[39:32]),
    .group       (group)
  );

  smnpp_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .group   (group),
    .load    (load),
    .can_load(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// File: rtl/smnpp_checker.sv
// Port-level checks on the packer's stream handshakes and its bind to the top level.
module smnpp_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic m_tlast
);

  // A result that was offered and not taken is still offered.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before transfer");

  // An accepted item always puts a result on the output in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

  // No new item is taken while a group is still part way through delivery.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted in the middle of a result group");

  // Once the final result of a group goes out and nothing new came in, the output goes idle.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result repeated after the last transfer of its group");

  // The output is idle right after reset.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind sign_magnitude_nibble_plane_packer_top smnpp_checker u_smnpp_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tlast (m_tlast)
);

// File: tb/sign_magnitude_nibble_plane_packer_top_tb.sv
// Self-checking testbench for the sign-magnitude nibble plane packer, with a built-in predictor.
module sign_magnitude_nibble_plane_packer_top_tb import smnpp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PixelLimit = 4194304;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned LongHold   = 80;

  // Register indexes that the block does not implement.
  localparam logic [CfgIdxW-1:0] RegUnusedA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegUnusedB = 2'd3;

  typedef struct {
    logic [AddrW-1:0]   addr;
    logic [ByteW-1:0]   data;
    logic [SampleW-1:0] sample;
    logic               last;
  } plane_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [AddrW-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  sign_magnitude_nibble_plane_packer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the configuration and state of the block.
  logic             mode_decode = 1'b0;
  logic [AddrW-1:0] region_pixels = 23'd1;
  logic [AddrW-1:0] cur_pixel = '0;
  logic [3:0]       held_nibble_b = '0;
  logic [3:0]       held_nibble_c = '0;

  logic [InDataW-1:0] items_to_send[$];
  plane_beat_t        beats_due[$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        src_gap = 0;
  int unsigned        sink_gap = 0;
  int unsigned        hold_left = 0;
  int unsigned        hold_asked = 0;
  int unsigned        hold_served = 0;
  bit                 idle_on = 1'b1;

  function automatic logic [AddrW-1:0] effective_pixels();
    logic [AddrW-1:0] n;
    n = region_pixels;
    if (n == '0) n = 23'd1;
    if (n > PixelLimit) n = AddrW'(PixelLimit);
    return n;
  endfunction

  task automatic add_beat(input logic [AddrW-1:0] addr, input logic [ByteW-1:0] data,
                          input logic [SampleW-1:0] sample, input logic last);
    plane_beat_t b;
    b.addr = addr;
    b.data = data;
    b.sample = sample;
    b.last = last;
    beats_due.push_back(b);
  endtask

  task automatic pack_predict(input logic [InDataW-1:0] item);
    logic [AddrW-1:0]   npix, pix, half, base;
    logic               is_odd, is_final;
    logic [15:0]        x, mag, u, v;
    logic [14:0]        s;
    logic [7:0]         hi, lo, pb, pc, bb, cb;
    npix = effective_pixels();
    pix = (cur_pixel < npix) ? cur_pixel : '0;
    half = (npix + 23'd1) >> 1;
    is_odd = pix[0];
    is_final = (pix == npix - 23'd1);
    if (!mode_decode) begin
      x = item[15:0];
      if (x[15]) begin
        // Two's complement negate; the most negative sample lands on u = 1.
        mag = 16'h0000 - x;
        u = {mag[14:0], 1'b1};
      end else begin
        u = {x[14:0], 1'b0};
      end
      hi = u[15:8];
      if (!is_odd) begin
        held_nibble_b = hi[3:0];
        held_nibble_c = hi[7:4];
      end
      if (is_odd || is_final) begin
        bb = {held_nibble_b, is_odd ? hi[3:0] : 4'h0};
        cb = {held_nibble_c, is_odd ? hi[7:4] : 4'h0};
        base = npix + (pix >> 1);
        add_beat(pix, u[7:0], '0, 1'b0);
        add_beat(base, bb, '0, 1'b0);
        add_beat(base + half, cb, '0, 1'b1);
      end else begin
        add_beat(pix, u[7:0], '0, 1'b1);
      end
    end else begin
      lo = item[23:16];
      pb = item[31:24];
      pc = item[39:32];
      hi = is_odd ? {pc[3:0], pb[3:0]} : {pc[7:4], pb[7:4]};
      u = {hi, lo};
      s = u[15:1];
      if (u[0]) v = (s == '0) ? 16'h8000 : (16'h0000 - {1'b0, s});
      else v = {1'b0, s};
      add_beat('0, '0, v, 1'b1);
    end
    cur_pixel = (pix + 23'd1 >= npix) ? '0 : pix + 23'd1;
  endtask

  // Source side: offers queued items, predicts on each accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pack_predict(s_tdata);
      if (s_tvalid && !s_tready) begin
        // Hold the current item until it is taken.
      end else if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        s_tdata <= items_to_send.pop_front();
        s_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 5);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: checks each result transfer and throttles m_tready.
  always @(posedge clk) begin
    plane_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected result addr=%h byte=%h sample=%h last=%b", $time,
                   m_tdata[22:0], m_tdata[30:23], m_tdata[46:31], m_tlast);
          mismatch_count++;
        end else begin
          want = beats_due.pop_front();
          if (m_tdata[22:0] !== want.addr) begin
            $display("%0t: out_addr expected %h actual %h", $time, want.addr, m_tdata[22:0]);
            mismatch_count++;
          end
          if (m_tdata[30:23] !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata[30:23]);
            mismatch_count++;
          end
          if (m_tdata[46:31] !== want.sample) begin
            $display("%0t: out_sample expected %h actual %h", $time, want.sample,
                     m_tdata[46:31]);
            mismatch_count++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: out_last expected %b actual %b", $time, want.last, m_tlast);
            mismatch_count++;
          end
        end
      end
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [InDataW-1:0] make_item(input logic [15:0] sample,
                                                   input logic [7:0] lo,
                                                   input logic [7:0] pb,
                                                   input logic [7:0] pc);
    return {pc, pb, lo, sample};
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [InDataW-1:0] random_item();
    return make_item(pick_sample(), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegDirection) mode_decode = val[0];
    else if (idx == RegPixelCount) region_pixels = val;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_to_send.size() != 0 || s_tvalid || beats_due.size() != 0);
  endtask

  task automatic send_samples(input int unsigned n);
    repeat (n) items_to_send.push_back(random_item());
  endtask

  initial begin
    logic [AddrW-1:0] count_pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // One-pixel region: every pixel is a final even pixel.
    write_reg(RegDirection, 23'd0);
    write_reg(RegPixelCount, 23'd1);
    items_to_send.push_back(make_item(16'h0000, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'h7FFF, 8'hFF, 8'hFF, 8'hFF));
    items_to_send.push_back(make_item(16'h8000, 8'h5A, 8'hA5, 8'h3C));
    items_to_send.push_back(make_item(16'hFFFF, 8'hC3, 8'h0F, 8'hF0));
    wait_drained();
    // A count of zero acts as one.
    write_reg(RegPixelCount, 23'd0);
    items_to_send.push_back(make_item(16'h0001, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'h8001, 8'h00, 8'h00, 8'h00));
    wait_drained();

    // Odd count, wraps twice with a final even pixel each time.
    write_reg(RegPixelCount, 23'd5);
    items_to_send.push_back(make_item(16'h7FFF, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'h8000, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'hFFFF, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'h1234, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'hEDCB, 8'h00, 8'h00, 8'h00));
    send_samples(5);
    wait_drained();

    // Decode, with writes to unused register indexes that must be ignored.
    write_reg(RegUnusedA, 23'h7FFFFF);
    write_reg(RegUnusedB, 23'h555555);
    write_reg(RegDirection, 23'd1);
    items_to_send.push_back(make_item(16'h0000, 8'h01, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'h0000, 8'h01, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'hFFFF, 8'h00, 8'h00, 8'h00));
    items_to_send.push_back(make_item(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    items_to_send.push_back(make_item(16'h0000, 8'hFE, 8'hFF, 8'hFF));
    wait_drained();

    // Count shrinks below the current index: the next item is pixel zero.
    write_reg(RegDirection, 23'd0);
    write_reg(RegPixelCount, 23'd8);
    send_samples(3);
    wait_drained();
    write_reg(RegPixelCount, 23'd2);
    send_samples(2);
    wait_drained();

    // Counts at and above the largest region.
    write_reg(RegPixelCount, 23'h7FFFFF);
    send_samples(2);
    wait_drained();
    write_reg(RegPixelCount, AddrW'(PixelLimit));
    send_samples(2);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase < 6) && (phase != 1);
      write_reg(RegDirection, 23'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
        0: count_pick = '0;
        1: count_pick = 23'($urandom);
        2: count_pick = 23'd2;
        default: count_pick = 23'($urandom_range(1, 12));
      endcase
      write_reg(RegPixelCount, count_pick);
      // The sink stalls for a long stretch while items keep coming.
      if (phase == 2) hold_asked++;
      send_samples((phase == 2) ? 20 : 10);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && beats_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/smnpp_pkg.sv
rtl/smnpp_core.sv
rtl/smnpp_outbuf.sv
rtl/sign_magnitude_nibble_plane_packer_top.sv
rtl/smnpp_checker.sv
tb/sign_magnitude_nibble_plane_packer_top_tb.sv
